[design/uer_pkg.sv]
// Shared constants, types and codes of the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

  localparam int MAX_RANGE        = 500;
  localparam int ROUNDTRIP_TICKS  = 57;
  localparam int START_WAIT_TICKS = 5800;
  localparam int OVERHEAD_TICKS   = 5;

  localparam int TRIG_LOW_TICKS  = 4;
  localparam int TRIG_HIGH_TICKS = 10;

  localparam int LIMIT_MAX = (MAX_RANGE + 1) * ROUNDTRIP_TICKS;
  localparam int LIMIT_W   = $clog2(LIMIT_MAX + 1);
  localparam int CNT_W     = $clog2(LIMIT_MAX + START_WAIT_TICKS + 2);

  localparam int DIST_W    = 9;
  localparam int ETIME_W   = 15;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int PHASE_W   = 3;

  localparam logic [DIST_W-1:0]  DIST_RESET = 9'd500;
  localparam logic [ETIME_W-1:0] ETIME_MAX  = 15'h7fff;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDING_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ACTIVE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MEASURED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ECHO_AT_START = 2'd1;
  localparam logic [STATUS_W-1:0] ST_START_TIMEOUT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ECHO_TIMEOUT  = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LOW   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ARMED = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TIME  = 3'd5;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic                trigger_level;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [ETIME_W-1:0]  echo_time;
  } out_item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               echo_active_level;
  } cfg_t;

endpackage
`default_nettype wire

[design/uer_if.sv]
// Handshake channel interfaces: input ticks, results and configuration writes.
`default_nettype none
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;
  modport source (output valid, start_req, echo_level, input ready);
  modport sink (input valid, start_req, echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*;;
  logic                valid;
  logic                ready;
  logic                trigger_level;
  logic                busy_res;
  logic                done_res;
  logic [STATUS_W-1:0] status;
  logic [ETIME_W-1:0]  echo_time;
  modport source (output valid, trigger_level, busy_res, done_res, status, echo_time,
                  input ready);
  modport sink (input valid, trigger_level, busy_res, done_res, status, echo_time,
                output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/uer_cfg.sv]
// Configuration registers and echo limit derivation.
`default_nettype none
module uer_cfg import uer_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  uer_cfg_if.sink      cfg_if,
  output cfg_t         cfg
);

  logic [DIST_W-1:0]  range_r, range_nxt;
  logic               rounding_mode_r, rounding_mode_nxt;
  logic               echo_active_r, echo_active_nxt;
  logic [LIMIT_W-1:0] range_clamped;
  logic [LIMIT_W-1:0] base;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    range_nxt         = range_r;
    rounding_mode_nxt = rounding_mode_r;
    echo_active_nxt   = echo_active_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_RANGE:         range_nxt         = cfg_if.data[DIST_W-1:0];
        REG_ROUNDING_MODE: rounding_mode_nxt = cfg_if.data[0];
        REG_ECHO_ACTIVE:   echo_active_nxt   = cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r         <= DIST_RESET;
      rounding_mode_r <= 1'b0;
      echo_active_r   <= 1'b1;
    end else begin
      range_r         <= range_nxt;
      rounding_mode_r <= rounding_mode_nxt;
      echo_active_r   <= echo_active_nxt;
    end
  end

  // clamp distance, then round trips of the chosen rounding
  always_comb begin
    if (32'(range_r) > MAX_RANGE) begin
      range_clamped = LIMIT_W'(MAX_RANGE);
    end else begin
      range_clamped = LIMIT_W'(range_r);
    end
    base = range_clamped + LIMIT_W'(!rounding_mode_r);
    cfg.limit = LIMIT_W'(base * LIMIT_W'(ROUNDTRIP_TICKS))
              + (rounding_mode_r ? LIMIT_W'(ROUNDTRIP_TICKS / 2) : LIMIT_W'(0));
    cfg.echo_active_level = echo_active_r;
  end

endmodule
`default_nettype wire

[design/uer_seq.sv]
// Measurement sequencer: phase, counters and per-tick result.
`default_nettype none
module uer_seq import uer_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      advance,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      res
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   wait_r, wait_nxt;
  logic [CNT_W-1:0]   pulse_r, pulse_nxt;

  always_comb begin
    logic [PHASE_W-1:0] ph;
    logic [CNT_W-1:0]   wc;
    logic [CNT_W-1:0]   pc;
    logic [CNT_W-1:0]   tsub;
    logic               active;
    active = (item.echo_level == cfg.echo_active_level);
    ph = phase_r;
    wc = wait_r;
    pc = pulse_r;
    tsub = '0;
    res = '0;
    if (ph == PH_IDLE && item.start_req) begin
      ph = PH_LOW;
      wc = '0;
      pc = '0;
    end
    phase_nxt = ph;
    wait_nxt  = wc;
    pulse_nxt = pc;
    unique case (ph)
      PH_IDLE: begin
      end
      PH_LOW: begin
        res.busy_res = 1'b1;
        wait_nxt = wc + CNT_W'(1);
        if (wait_nxt >= CNT_W'(TRIG_LOW_TICKS)) begin
          phase_nxt = PH_HIGH;
          wait_nxt  = '0;
        end
      end
      PH_HIGH: begin
        res.busy_res      = 1'b1;
        res.trigger_level = 1'b1;
        wait_nxt = wc + CNT_W'(1);
        if (wait_nxt >= CNT_W'(TRIG_HIGH_TICKS)) begin
          phase_nxt = PH_ARMED;
          wait_nxt  = '0;
        end
      end
      PH_ARMED: begin
        if (active) begin
          res.done_res = 1'b1;
          res.status   = ST_ECHO_AT_START;
          phase_nxt    = PH_IDLE;
        end else begin
          res.busy_res = 1'b1;
          wait_nxt     = '0;
          phase_nxt    = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (active) begin
          res.busy_res = 1'b1;
          pulse_nxt    = '0;
          phase_nxt    = PH_TIME;
        end else begin
          wait_nxt = wc + CNT_W'(1);
          if (wait_nxt > CNT_W'(cfg.limit) + CNT_W'(START_WAIT_TICKS)) begin
            res.done_res = 1'b1;
            res.status   = ST_START_TIMEOUT;
            phase_nxt    = PH_IDLE;
          end else begin
            res.busy_res = 1'b1;
          end
        end
      end
      PH_TIME: begin
        pulse_nxt = pc + CNT_W'(1);
        if (!active) begin
          if (pulse_nxt > CNT_W'(OVERHEAD_TICKS)) begin
            tsub = pulse_nxt - CNT_W'(OVERHEAD_TICKS);
          end
          res.done_res = 1'b1;
          res.status   = ST_MEASURED;
          if (32'(tsub) > 32'(ETIME_MAX)) begin
            res.echo_time = ETIME_MAX;
          end else begin
            res.echo_time = ETIME_W'(tsub);
          end
          phase_nxt = PH_IDLE;
        end else if (pulse_nxt > CNT_W'(cfg.limit)) begin
          res.done_res = 1'b1;
          res.status   = ST_ECHO_TIMEOUT;
          phase_nxt    = PH_IDLE;
        end else begin
          res.busy_res = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      pulse_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  a_low_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LOW) |-> (wait_r < CNT_W'(TRIG_LOW_TICKS)))
    else $error("trigger low count out of range");

  a_high_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == PH_HIGH && wait_r == CNT_W'(TRIG_HIGH_TICKS - 1))
    |=> (phase_r == PH_ARMED))
    else $error("trigger pulse did not end after its high ticks");

  a_trig_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.trigger_level |-> (phase_r == PH_HIGH))
    else $error("trigger driven outside high phase");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == PH_IDLE && !item.start_req) |=> (phase_r == PH_IDLE))
    else $error("left idle without a start request");

  a_time_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res.echo_time != '0) |-> (res.done_res && res.status == ST_MEASURED))
    else $error("echo time reported without a finished measurement");

endmodule
`default_nettype wire

[design/ultrasonic_echo_ranger_unit.sv]
// Ultrasonic echo ranger top level: input register, sequencer, result register.
//
// Usage:
//   in_if  : one request per microsecond tick carrying start_req and the
//            sampled echo_level. Every tick must be sent to keep time.
//   out_if : one result per request: trigger_level, busy_res, done_res,
//            status and echo_time (nonzero only when done with status 0).
//   cfg_if : register writes (0 range, 1 rounding_mode,
//            2 echo_active_level), always ready; write only while idle.
// Timing:
//   A request is taken into the input register, processed in one pass of
//   the sequencer logic and its result loaded into the output register
//   once that register is empty or its result is being taken.
//   One request per cycle is sustained while out_if.ready stays high; the
//   sequencer state register updates once per request.
// Reset (rst_n low, synchronous): both stages empty, sequencer idle,
//   registers back to distance 500, rounding mode 0, active level high.
// Stall: with out_if.ready low the result holds; the input register still
//   takes one more request, then in_if.ready drops until the result leaves.
`default_nettype none
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uer_in_if.sink     in_if,
  uer_out_if.source  out_if,
  uer_cfg_if.sink    cfg_if
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r, in_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      advance;
  out_item_t res;
  cfg_t      cfg;

  uer_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  uer_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (in_if.valid && in_if.ready) begin
      in_valid_nxt           = 1'b1;
      in_item_nxt.start_req  = in_if.start_req;
      in_item_nxt.echo_level = in_if.echo_level;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.trigger_level = out_item_r.trigger_level;
  assign out_if.busy_res      = out_item_r.busy_res;
  assign out_if.done_res      = out_item_r.done_res;
  assign out_if.status        = out_item_r.status;
  assign out_if.echo_time     = out_item_r.echo_time;

endmodule
`default_nettype wire

[tb/tb_ultrasonic_echo_ranger_unit.sv]
// Testbench for the ultrasonic echo ranger: tick-by-tick prediction and result checks.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_unit import uer_pkg::*;;

  class ranger_tracker;
    logic [DIST_W-1:0]  max_dist;
    logic               round_half;
    logic               active_lvl;
    logic [PHASE_W-1:0] phase;
    int unsigned        wait_cnt;
    int unsigned        pulse_cnt;
    out_item_t          expected_ticks[$];
    int                 fail_count;

    function new();
      max_dist   = DIST_RESET;
      round_half = 1'b0;
      active_lvl = 1'b1;
      phase      = PH_IDLE;
      wait_cnt   = 0;
      pulse_cnt  = 0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_RANGE:         max_dist = data[DIST_W-1:0];
        REG_ROUNDING_MODE: round_half = data[0];
        REG_ECHO_ACTIVE:   active_lvl = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned echo_limit();
      int unsigned d;
      d = (max_dist > MAX_RANGE) ? MAX_RANGE : max_dist;
      if (!round_half) return (d + 1) * ROUNDTRIP_TICKS;
      return d * ROUNDTRIP_TICKS + ROUNDTRIP_TICKS / 2;
    endfunction

    function void take_request(logic start, logic echo);
      out_item_t   r;
      logic        act;
      int unsigned lim;
      int unsigned t;
      r   = '0;
      act = (echo == active_lvl);
      lim = echo_limit();
      if (phase == PH_IDLE && start) begin
        phase     = PH_LOW;
        wait_cnt  = 0;
        pulse_cnt = 0;
      end
      case (phase)
        PH_IDLE: ;
        PH_LOW: begin
          r.busy_res = 1'b1;
          wait_cnt++;
          if (wait_cnt >= TRIG_LOW_TICKS) begin
            phase    = PH_HIGH;
            wait_cnt = 0;
          end
        end
        PH_HIGH: begin
          r.busy_res      = 1'b1;
          r.trigger_level = 1'b1;
          wait_cnt++;
          if (wait_cnt >= TRIG_HIGH_TICKS) begin
            phase    = PH_ARMED;
            wait_cnt = 0;
          end
        end
        PH_ARMED: begin
          if (act) begin
            r.done_res = 1'b1;
            r.status   = ST_ECHO_AT_START;
            phase      = PH_IDLE;
          end else begin
            r.busy_res = 1'b1;
            wait_cnt   = 0;
            phase      = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (act) begin
            r.busy_res = 1'b1;
            pulse_cnt  = 0;
            phase      = PH_TIME;
          end else begin
            if (wait_cnt != 32'hffff_ffff) wait_cnt++;
            if (wait_cnt > lim + START_WAIT_TICKS) begin
              r.done_res = 1'b1;
              r.status   = ST_START_TIMEOUT;
              phase      = PH_IDLE;
            end else begin
              r.busy_res = 1'b1;
            end
          end
        end
        PH_TIME: begin
          if (pulse_cnt != 32'hffff_ffff) pulse_cnt++;
          if (!act) begin
            t = (pulse_cnt > OVERHEAD_TICKS) ? pulse_cnt - OVERHEAD_TICKS : 0;
            if (t > ETIME_MAX) t = ETIME_MAX;
            r.done_res  = 1'b1;
            r.status    = ST_MEASURED;
            r.echo_time = t[ETIME_W-1:0];
            phase       = PH_IDLE;
          end else if (pulse_cnt > lim) begin
            r.done_res = 1'b1;
            r.status   = ST_ECHO_TIMEOUT;
            phase      = PH_IDLE;
          end else begin
            r.busy_res = 1'b1;
          end
        end
        default: phase = PH_IDLE;
      endcase
      expected_ticks.push_back(r);
    endfunction

    function void compare(string field, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, exp, act);
        fail_count++;
      end
    endfunction

    function void check_tick(out_item_t got);
      out_item_t exp;
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        fail_count++;
        return;
      end
      exp = expected_ticks.pop_front();
      compare("trigger_level", 32'(exp.trigger_level), 32'(got.trigger_level));
      compare("busy_res", 32'(exp.busy_res), 32'(got.busy_res));
      compare("done_res", 32'(exp.done_res), 32'(got.done_res));
      compare("status", 32'(exp.status), 32'(got.status));
      compare("echo_time", 32'(exp.echo_time), 32'(got.echo_time));
    endfunction
  endclass

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TICK_TARGET    = 1900;

  logic clk;
  logic rst_n;
  logic steady;
  int   stall_cycles;
  int   ticks_sent;
  int   phase_no;

  ranger_tracker tracker = new();

  uer_in_if  in_if();
  uer_out_if out_if();
  uer_cfg_if cfg_if();

  ultrasonic_echo_ranger_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.check_tick({out_if.trigger_level, out_if.busy_res, out_if.done_res,
                          out_if.status, out_if.echo_time});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ultrasonic_echo_ranger_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    if (!steady && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= start;
    in_if.echo_level <= echo;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_request(start, echo);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.write_reg(idx, data);
  endtask

  // finish any measurement, hold requests and drain results
  task automatic settle();
    while (tracker.phase != PH_IDLE) begin
      send_tick(1'b0, (tracker.phase == PH_WAIT) ? tracker.active_lvl : ~tracker.active_lvl);
    end
    in_if.valid <= 1'b0;
    while (tracker.expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input int range_val, input logic half, input logic lvl);
    logic [CFG_DAT_W-2:0] junk;
    settle();
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_RANGE, range_val[CFG_DAT_W-1:0]);
    write_reg(REG_ROUNDING_MODE, {junk, half});
    junk = (CFG_DAT_W-1)'($urandom);
    write_reg(REG_ECHO_ACTIVE, {junk, lvl});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic measure(input int idle_ticks, input bit at_start, input int unsigned wait_ticks,
                         input int unsigned pulse_ticks);
    logic        act;
    int unsigned n;
    act = tracker.active_lvl;
    repeat (idle_ticks) send_tick(1'b0, 1'($urandom_range(1)));
    send_tick(1'b1, 1'($urandom_range(1)));
    while (tracker.phase == PH_LOW || tracker.phase == PH_HIGH) begin
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    if (at_start) begin
      send_tick(1'($urandom_range(1)), act);
    end else begin
      send_tick(1'($urandom_range(1)), ~act);
      n = 0;
      while (tracker.phase == PH_WAIT && n < wait_ticks) begin
        send_tick(1'($urandom_range(1)), ~act);
        n++;
      end
      if (tracker.phase == PH_WAIT) send_tick(1'($urandom_range(1)), act);
      n = 0;
      while (tracker.phase == PH_TIME && n < pulse_ticks) begin
        send_tick(1'($urandom_range(1)), act);
        n++;
      end
      if (tracker.phase == PH_TIME) send_tick(1'($urandom_range(1)), ~act);
    end
  endtask

  task automatic random_measure();
    int unsigned lim;
    int          pick;
    int          idle;
    lim  = tracker.echo_limit();
    pick = $urandom_range(99);
    idle = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(4);
    if (pick < 10) begin
      measure(idle, 1'b1, 0, 0);
    end else if (pick < 22 && lim < 150) begin
      measure(idle, 1'b0, $urandom_range(20), lim + $urandom_range(2));
    end else if (pick < 34) begin
      measure(idle, 1'b0, $urandom_range(5), $urandom_range(lim < 8 ? lim : 8));
    end else begin
      measure(idle, 1'b0, $urandom_range(40), $urandom_range(lim < 120 ? lim : 120));
    end
  endtask

  initial begin
    logic [CFG_DAT_W-1:0] junk;
    rst_n            <= 1'b0;
    steady           <= 1'b1;
    in_if.valid      <= 1'b0;
    in_if.start_req  <= 1'b0;
    in_if.echo_level <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_RANGE;
    cfg_if.data      <= '0;
    ticks_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values, then the corner cases of each phase
    measure(2, 1'b0, 3, 100);
    measure(0, 1'b1, 0, 0);
    set_regs(0, 1'b0, 1'b1);
    measure(1, 1'b0, 5, 0);
    measure(0, 1'b0, 2, 4);
    measure(0, 1'b0, 2, 5);
    measure(0, 1'b0, 0, 57);
    measure(0, 1'b0, 0, 58);
    set_regs(0, 1'b1, 1'b0);
    measure(0, 1'b0, 0, 28);
    measure(0, 1'b0, 0, 29);
    measure(0, 1'b1, 0, 0);
    settle();
    junk = CFG_DAT_W'($urandom);
    write_reg(REG_UNUSED, junk);
    cfg_if.valid <= 1'b0;
    measure(3, 1'b0, 10, 20);
    set_regs(511, 1'b1, 1'b1);
    measure(0, 1'b0, 4, 150);
    set_regs(500, 1'b0, 1'b1);
    measure(0, 1'b0, 6, 200);

    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      steady <= (phase_no == 2) || (phase_no == 3);
      set_regs(($urandom_range(3) != 0) ? $urandom_range(12) : $urandom_range(511),
               1'($urandom_range(1)), 1'($urandom_range(1)));
      repeat ($urandom_range(5, 2)) begin
        if (ticks_sent < TICK_TARGET) random_measure();
      end
      phase_no++;
    end

    in_if.valid <= 1'b0;
    while (tracker.expected_ticks.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.expected_ticks.size() == 0) begin
      $display("ultrasonic_echo_ranger_unit: match");
    end else begin
      $display("ultrasonic_echo_ranger_unit: mismatch");
    end
    $finish;
  end

endmodule
